// File: hdl/blcl_pkg.sv
`timescale 1ns / 1ps
package blcl_pkg;
  localparam int NUM_SLOTS   = 16;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int BLOCK_W     = 16;
  localparam int BLOCK_BYTES = 1 << BLOCK_W;
  localparam int LOAD_W      = BLOCK_W + 1;
  localparam int TAG_W       = 32 - BLOCK_W;
  localparam int MAX_SEGS    = 3;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    ACT_HIT    = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_BYPASS = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef struct packed {
    logic  hit;
    slot_t hit_slot;
    logic  any_free;
    slot_t free_slot;
  } blcl_look_t;

  typedef struct packed {
    logic              en;
    slot_t             slot;
    logic [TAG_W-1:0]  tag;
    logic [LOAD_W-1:0] loaded;
  } blcl_fill_t;
endpackage

// File: hdl/block_cache_lru_lookup.sv
`timescale 1ns / 1ps
// Lookup controller for a 16-slot fully associative block cache. Assert start
// while busy is low; each result beat appears for one cycle with strobe high
// and cannot be stalled. An empty or bypass request is answered from the check
// state alone; a cached request then looks up each segment in turn, and a
// segment that must evict first waits for the LRU victim, which is found by
// scanning the stamp RAM one slot per cycle. The user must write file_length
// through cfg_valid/cfg_ready only while idle; the block does not enforce it.
module block_cache_lru_lookup import blcl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] req_offset,
  input  logic [31:0] req_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] file_length,
  output logic        strobe,
  output logic [1:0]  action,
  output logic [3:0]  slot,
  output logic [31:0] block_base,
  output logic [16:0] fill_length,
  output logic [15:0] index_in_block,
  output logic [31:0] byte_count,
  output logic [16:0] dest_offset,
  output logic        last
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_LOOK  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FILL  = 5'b10000
  } state_t;

  state_t            state;
  logic [31:0]       flen;
  logic [31:0]       off;
  logic [31:0]       len;
  logic [LOAD_W-1:0] done;
  logic [1:0]        nseg;
  logic [31:0]       use_stamp;
  logic [SLOT_W:0]   scan_cnt;
  logic              scan_vld;
  slot_t             scan_idx;
  logic [31:0]       min_stamp;
  slot_t             victim;

  logic [31:0]       pos;
  blcl_look_t        look;
  blcl_fill_t        fill;
  slot_t             sel;
  logic              emit_seg;
  logic              is_fill;
  logic [LOAD_W-1:0] rd_loaded;
  logic [31:0]       base;
  logic [31:0]       flen_rem;
  logic [LOAD_W-1:0] fill_len;
  logic [LOAD_W-1:0] seg_loaded;
  logic [LOAD_W-1:0] avail;
  logic [LOAD_W-1:0] remain;
  logic [LOAD_W-1:0] want;
  logic [LOAD_W-1:0] done_next;
  logic              seg_last;
  logic [31:0]       stamp_next;
  logic [31:0]       rdata;
  logic [31:0]       len_room;
  logic [31:0]       len_clamp;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign pos       = off + 32'(done);

  assign base     = {pos[31:BLOCK_W], {BLOCK_W{1'b0}}};
  assign flen_rem = flen - base;
  assign fill_len = (flen_rem > 32'(BLOCK_BYTES)) ? LOAD_W'(BLOCK_BYTES)
                                                   : flen_rem[LOAD_W-1:0];

  always_comb begin
    emit_seg = 1'b0;
    is_fill  = 1'b0;
    sel      = victim;
    if (state == S_LOOK) begin
      if (look.hit) begin
        emit_seg = 1'b1;
        sel      = look.hit_slot;
      end else if (look.any_free) begin
        emit_seg = 1'b1;
        is_fill  = 1'b1;
        sel      = look.free_slot;
      end
    end else if (state == S_FILL) begin
      emit_seg = 1'b1;
      is_fill  = 1'b1;
    end
  end

  assign seg_loaded = is_fill ? fill_len : rd_loaded;
  assign avail      = seg_loaded - {1'b0, pos[BLOCK_W-1:0]};
  assign remain     = len[LOAD_W-1:0] - done;
  assign want       = (remain > avail) ? avail : remain;
  assign done_next  = done + want;
  assign seg_last   = (done_next >= len[LOAD_W-1:0]);
  assign stamp_next = use_stamp + (is_fill ? 32'd2 : 32'd1);

  assign fill.en     = emit_seg && is_fill;
  assign fill.slot   = sel;
  assign fill.tag    = pos[31:BLOCK_W];
  assign fill.loaded = fill_len;

  assign len_room  = flen - off;
  assign len_clamp = (len > len_room) ? len_room : len;

  blcl_tag_store u_tags (
    .clk       (clk),
    .rst       (rst),
    .fill      (fill),
    .pos       (pos),
    .rd_slot   (sel),
    .look      (look),
    .rd_loaded (rd_loaded)
  );

  blcl_stamp_ram u_stamps (
    .clk   (clk),
    .we    (emit_seg),
    .waddr (sel),
    .wdata (stamp_next),
    .raddr (scan_cnt[SLOT_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flen <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      flen <= file_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      strobe    <= 1'b0;
      use_stamp <= '0;
      scan_vld  <= 1'b0;
    end else begin
      strobe   <= 1'b0;
      scan_vld <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            off   <= req_offset;
            len   <= req_length;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          strobe         <= 1'b1;
          slot           <= '0;
          fill_length    <= '0;
          index_in_block <= '0;
          dest_offset    <= '0;
          last           <= 1'b1;
          done           <= '0;
          nseg           <= '0;
          if (len == 32'd0 || off >= flen) begin
            action     <= ACT_NONE;
            block_base <= '0;
            byte_count <= '0;
            state      <= S_IDLE;
          end else if (len_clamp >= 32'(2 * BLOCK_BYTES)) begin
            action     <= ACT_BYPASS;
            block_base <= off;
            byte_count <= len_clamp;
            state      <= S_IDLE;
          end else begin
            strobe <= 1'b0;
            len    <= len_clamp;
            state  <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (!emit_seg) begin
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!scan_cnt[SLOT_W]) begin
            scan_cnt <= scan_cnt + 1'b1;
            scan_vld <= 1'b1;
            scan_idx <= scan_cnt[SLOT_W-1:0];
          end
          if (scan_vld) begin
            if (scan_idx == '0 || rdata < min_stamp) begin
              min_stamp <= rdata;
              victim    <= scan_idx;
            end
            if (scan_idx == slot_t'(NUM_SLOTS - 1)) begin
              state <= S_FILL;
            end
          end
        end
        S_FILL: ;
        default: state <= S_IDLE;
      endcase

      if (emit_seg) begin
        strobe         <= 1'b1;
        action         <= is_fill ? ACT_FILL : ACT_HIT;
        slot           <= 4'(sel);
        block_base     <= base;
        fill_length    <= is_fill ? fill_len : '0;
        index_in_block <= pos[BLOCK_W-1:0];
        byte_count     <= 32'(want);
        dest_offset    <= done;
        last           <= seg_last;
        use_stamp      <= stamp_next;
        done           <= done_next;
        nseg           <= nseg + 1'b1;
        if (seg_last || nseg == 2'(MAX_SEGS - 1)) begin
          state <= S_IDLE;
        end else begin
          state <= S_LOOK;
        end
      end
    end
  end

  a_strobe_from_work: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result beat without work in progress");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("busy after final beat");

  a_fill_stamp: assert property (@(posedge clk) disable iff (rst)
    fill.en |=> (use_stamp == $past(use_stamp) + 32'd2))
    else $error("fill stamp step wrong");

  a_scan_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !strobe || $past(emit_seg) == 1'b0)
    else $error("beat during victim scan");
endmodule

// File: hdl/blcl_stamp_ram.sv
`timescale 1ns / 1ps
module blcl_stamp_ram import blcl_pkg::*; (
  input  logic        clk,
  input  logic        we,
  input  slot_t       waddr,
  input  logic [31:0] wdata,
  input  slot_t       raddr,
  output logic [31:0] rdata
);
  logic [31:0] mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/blcl_tag_store.sv
`timescale 1ns / 1ps
module blcl_tag_store import blcl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  blcl_fill_t        fill,
  input  logic [31:0]       pos,
  input  slot_t             rd_slot,
  output blcl_look_t        look,
  output logic [LOAD_W-1:0] rd_loaded
);
  logic [NUM_SLOTS-1:0] valid;
  logic [TAG_W-1:0]     tag    [NUM_SLOTS];
  logic [LOAD_W-1:0]    loaded [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (fill.en) begin
      valid[fill.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill.en) begin
      tag[fill.slot]    <= fill.tag;
      loaded[fill.slot] <= fill.loaded;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match[i] = valid[i] && (tag[i] == pos[31:BLOCK_W])
                 && ({1'b0, pos[BLOCK_W-1:0]} < loaded[i]);
    end
  end

  always_comb begin
    look = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        look.hit      = 1'b1;
        look.hit_slot = SLOT_W'(i);
      end
      if (!valid[i]) begin
        look.any_free  = 1'b1;
        look.free_slot = SLOT_W'(i);
      end
    end
  end

  assign rd_loaded = loaded[rd_slot];
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import blcl_pkg::*;

  typedef struct packed {
    action_t     act;
    slot_t       s;
    logic [31:0] base;
    logic [16:0] fill;
    logic [15:0] idx;
    logic [31:0] cnt;
    logic [16:0] dest;
    logic        fin;
  } segment_t;

  class lru_scoreboard;
    bit [31:0] flen;
    bit        vld[NUM_SLOTS];
    bit [15:0] tag[NUM_SLOTS];
    bit [31:0] stamp[NUM_SLOTS];
    bit [31:0] loaded[NUM_SLOTS];
    bit [31:0] use_clock;
    segment_t  expected_segs[$];
    int        errors;
    int        checked;
    int        requests;

    function new();
      flen = 1;
      use_clock = 0;
      errors = 0;
      checked = 0;
      requests = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        vld[i] = 0;
        tag[i] = 0;
        stamp[i] = 0;
        loaded[i] = 0;
      end
    endfunction

    function void push_seg(action_t a, int s, longint unsigned b, longint unsigned fl,
                           longint unsigned ix, longint unsigned c,
                           longint unsigned d, bit f);
      segment_t e;
      e.act = a;
      e.s = s[SLOT_W-1:0];
      e.base = b[31:0];
      e.fill = fl[16:0];
      e.idx = ix[15:0];
      e.cnt = c[31:0];
      e.dest = d[16:0];
      e.fin = f;
      expected_segs.push_back(e);
    endfunction

    function void note_request(bit [31:0] off, bit [31:0] len_in);
      longint unsigned o, l, f, done, pos, base, idx, avail, want, fl;
      int n, s;
      action_t a;
      o = off;
      l = len_in;
      f = flen;
      done = 0;
      n = 0;
      requests++;
      if (l == 0 || o >= f) begin
        push_seg(ACT_NONE, 0, 0, 0, 0, 0, 0, 1);
        return;
      end
      if (l > f - o) l = f - o;
      if (l >= 2 * BLOCK_BYTES) begin
        push_seg(ACT_BYPASS, 0, o, 0, 0, l, 0, 1);
        return;
      end
      while (done < l && n < 3) begin
        pos = o + done;
        fl = 0;
        a = ACT_HIT;
        s = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          longint unsigned b;
          b = longint'(tag[i]) * BLOCK_BYTES;
          if (s < 0 && vld[i] && pos >= b && pos < b + loaded[i]) s = i;
        end
        if (s < 0) begin
          base = (pos / BLOCK_BYTES) * BLOCK_BYTES;
          fl = f - base;
          if (fl > BLOCK_BYTES) fl = BLOCK_BYTES;
          s = 0;
          for (int i = NUM_SLOTS - 1; i >= 0; i--)
            if (stamp[i] <= stamp[s]) s = i;
          for (int i = NUM_SLOTS - 1; i >= 0; i--)
            if (!vld[i]) s = i;
          vld[s] = 1;
          tag[s] = 16'(pos / BLOCK_BYTES);
          loaded[s] = 32'(fl);
          use_clock++;
          a = ACT_FILL;
        end
        use_clock++;
        stamp[s] = use_clock;
        base = longint'(tag[s]) * BLOCK_BYTES;
        idx = pos - base;
        avail = longint'(loaded[s]) - idx;
        want = l - done;
        if (want > avail) want = avail;
        push_seg(a, s, base, fl, idx, want, done, (done + want >= l));
        done += want;
        n++;
      end
    endfunction

    function void check(segment_t got);
      segment_t e;
      checked++;
      if (expected_segs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %p", got);
        return;
      end
      e = expected_segs.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at beat %0d", checked);
          $display("  expected act=%0d slot=%0d base=%h fill=%h idx=%h cnt=%h dest=%h last=%b",
                   e.act, e.s, e.base, e.fill, e.idx, e.cnt, e.dest, e.fin);
          $display("  actual   act=%0d slot=%0d base=%h fill=%h idx=%h cnt=%h dest=%h last=%b",
                   got.act, got.s, got.base, got.fill, got.idx, got.cnt, got.dest, got.fin);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] req_offset;
  logic [31:0] req_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] file_length;
  logic        strobe;
  logic [1:0]  action;
  logic [3:0]  slot;
  logic [31:0] block_base;
  logic [16:0] fill_length;
  logic [15:0] index_in_block;
  logic [31:0] byte_count;
  logic [16:0] dest_offset;
  logic        last;

  lru_scoreboard sb;
  int            idle_pct;

  block_cache_lru_lookup DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_offset(req_offset), .req_length(req_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .file_length(file_length),
    .strobe(strobe), .action(action), .slot(slot), .block_base(block_base),
    .fill_length(fill_length), .index_in_block(index_in_block),
    .byte_count(byte_count), .dest_offset(dest_offset), .last(last)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    segment_t got;
    if (!rst && strobe) begin
      got.act = action_t'(action);
      got.s = slot;
      got.base = block_base;
      got.fill = fill_length;
      got.idx = index_in_block;
      got.cnt = byte_count;
      got.dest = dest_offset;
      got.fin = last;
      sb.check(got);
    end
  end

  task automatic send_request(bit [31:0] off, bit [31:0] len);
    start <= 1'b1;
    req_offset <= off;
    req_length <= len;
    do @(posedge clk); while (busy);
    sb.note_request(off, len);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_file_length(bit [31:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_segs.size() != 0 || busy) @(posedge clk);
    cfg_valid <= 1'b1;
    file_length <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.flen = v;
  endtask

  task automatic random_request();
    bit [31:0] off, len;
    longint unsigned nblk;
    int        pick;
    nblk = (longint'(sb.flen) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    if (nblk > 24) nblk = 24;
    pick = $urandom_range(99);
    off = ($urandom_range(32'(nblk - 1)) * BLOCK_BYTES) + $urandom_range(BLOCK_BYTES - 1);
    if (pick < 55) len = $urandom_range(1, 3000);
    else if (pick < 75) len = $urandom_range(1, 2 * BLOCK_BYTES - 1);
    else if (pick < 82) len = $urandom();
    else if (pick < 87) len = 0;
    else if (pick < 92) begin
      off = $urandom();
      len = $urandom_range(1, 2 * BLOCK_BYTES);
    end else begin
      off = sb.flen - $urandom_range(0, 70000);
      len = $urandom_range(1, 200000);
    end
    send_request(off, len);
  endtask

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    bit [31:0] lens[4];
    int        idles[4];
    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    req_offset <= '0;
    req_length <= '0;
    cfg_valid <= 1'b0;
    file_length <= '0;
    idle_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_request(32'd0, 32'd1);
    send_request(32'd0, 32'd0);
    send_request(32'd1, 32'd5);
    send_request(32'd0, 32'hFFFF_FFFF);
    write_file_length(32'hFFFF_FFFF);
    send_request(32'd0, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFE, 32'd10);
    send_request(32'hFFFF_FFFF, 32'd1);
    send_request(32'd0, 32'd100);
    send_request(32'd65530, 32'd131071);
    send_request(32'd65530, 32'd131072);
    send_request(32'd65536, 32'd65536);
    send_request(32'd131071, 32'd2);
    for (int i = 3; i < 20; i++) send_request(i * BLOCK_BYTES, 32'd16);
    send_request(32'd3 * BLOCK_BYTES + 7, 32'd9);
    write_file_length(32'd200000);
    send_request(32'd131072, 32'd131072);
    send_request(32'd199999, 32'd1);

    lens[0] = 32'd5 * BLOCK_BYTES + 123;
    lens[1] = 32'd20 * BLOCK_BYTES;
    lens[2] = $urandom_range(1, 40 * BLOCK_BYTES);
    lens[3] = 32'hFFFF_FFFF;
    idles[0] = 0;
    idles[1] = 81;
    idles[2] = 0;
    idles[3] = 33;
    for (int ph = 0; ph < 4; ph++) begin
      write_file_length(lens[ph]);
      idle_pct = idles[ph];
      for (int k = 0; k < 102; k++) random_request();
    end
    write_file_length(32'd1);
    send_request(32'd0, 32'd1);

    start <= 1'b0;
    for (int w = 0; w < 100000 && sb.expected_segs.size() != 0; w++) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.expected_segs.size() != 0) sb.errors += sb.expected_segs.size();
    $display("covered %0d requests and %0d result beats over several file lengths",
             sb.requests, sb.checked);
    $display("errors: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: sim.f
hdl/blcl_pkg.sv
hdl/blcl_stamp_ram.sv
hdl/blcl_tag_store.sv
hdl/block_cache_lru_lookup.sv
sim/tb.sv
